// ===== rtl/preamble_deframer_iq_unpacker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the preamble deframer / IQ unpacker
// Concurrent checks on the clock with asynchronous active-low reset; they
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PREAMBLE_DEFRAMER_IQ_UNPACKER_CORE_ASSERT_SVH
`define PREAMBLE_DEFRAMER_IQ_UNPACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PDIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdiq: same-cycle check failed");

// next-cycle implication
`define PDIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdiq: next-cycle check failed");

`else

`define PDIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PDIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pdiq_pkg.sv =====
// ----------------------------------------------------------------------------
// pdiq_pkg
// Shared constants and types of the preamble deframer / IQ unpacker.
// ----------------------------------------------------------------------------
package pdiq_pkg;

	// sync pattern: seven fill bytes and one start byte
	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] SYNC_LAST = 8'hD5;
	localparam int         SYNC_LEN  = 8;

	// field and state widths
	localparam int BYTE_W   = 8;
	localparam int WIN_W    = 56;
	localparam int FILL_W   = 3;
	localparam int GATHER_W = 40;
	localparam int SAMPLE_W = 24;
	localparam int SLIP_W   = 16;
	localparam int RATE_W   = 8;
	localparam int PHASE_W  = 3;
	localparam int CMP_W    = 10;

	// bytes per sample pair in each mode
	localparam int PAIR_WIDE   = 6;
	localparam int PAIR_NARROW = 4;

	// rate indexes below this select 24-bit samples
	localparam logic [RATE_W-1:0] WIDE_LIMIT = 8'd8;

	localparam logic [SLIP_W-1:0] SLIP_MAX = 16'hFFFF;

	// one result beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re_sample;
		logic signed [SAMPLE_W-1:0] im_sample;
		logic                       block_last;
		logic [SLIP_W-1:0]          slip_bytes;
	} pair_t;

endpackage

// ===== rtl/pdiq_deframer.sv =====
// ----------------------------------------------------------------------------
// pdiq_deframer
// Input register, sync hunt, block byte counter and sample gathering. Each
// registered byte is consumed when out_ready is high and may yield a pair.
// ----------------------------------------------------------------------------
`include "preamble_deframer_iq_unpacker_core_assert.svh"

module pdiq_deframer #(
	parameter int BLOCK_BYTES  = 508,
	parameter int HEADER_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pdiq_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          cfg_wr_en,
	input  logic [pdiq_pkg::RATE_W-1:0]   cfg_wr_data,
	input  logic                          out_ready,
	output logic                          res_valid,
	output pdiq_pkg::pair_t               res
);

	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int PAY_LEN     = (BLOCK_BYTES > HEADER_BYTES) ? (BLOCK_BYTES - HEADER_BYTES) : 0;
	localparam int USED_WIDE   = (PAY_LEN / pdiq_pkg::PAIR_WIDE) * pdiq_pkg::PAIR_WIDE;
	localparam int USED_NARROW = (PAY_LEN / pdiq_pkg::PAIR_NARROW) * pdiq_pkg::PAIR_NARROW;

	localparam logic [pdiq_pkg::CMP_W-1:0] HDR_C        = pdiq_pkg::CMP_W'(HEADER_BYTES);
	localparam logic [pdiq_pkg::CMP_W-1:0] END_WIDE_C   = pdiq_pkg::CMP_W'(HEADER_BYTES + USED_WIDE);
	localparam logic [pdiq_pkg::CMP_W-1:0] END_NARROW_C =
		pdiq_pkg::CMP_W'(HEADER_BYTES + USED_NARROW);
	localparam logic [pdiq_pkg::CMP_W-1:0] BLK_LAST_C   = pdiq_pkg::CMP_W'(BLOCK_BYTES - 1);

	localparam logic [pdiq_pkg::PHASE_W-1:0] PH_LAST_WIDE   =
		pdiq_pkg::PHASE_W'(pdiq_pkg::PAIR_WIDE - 1);
	localparam logic [pdiq_pkg::PHASE_W-1:0] PH_LAST_NARROW =
		pdiq_pkg::PHASE_W'(pdiq_pkg::PAIR_NARROW - 1);
	localparam logic [pdiq_pkg::FILL_W-1:0]  FILL_FULL      = 3'd7;
	localparam logic [POS_W-1:0]             POS_START      = POS_W'(pdiq_pkg::SYNC_LEN);
	localparam logic [pdiq_pkg::WIN_W-1:0]   SYNC_WIN       =
		{(pdiq_pkg::WIN_W / pdiq_pkg::BYTE_W){pdiq_pkg::SYNC_BYTE}};

	// input stage
	logic                         valid_s1;
	logic [pdiq_pkg::BYTE_W-1:0]  byte_s1;

	// deframer state
	logic [pdiq_pkg::RATE_W-1:0]   rate_q;
	logic [pdiq_pkg::WIN_W-1:0]    window_q;
	logic [pdiq_pkg::FILL_W-1:0]   fill_q;
	logic                          in_block_q;
	logic [POS_W-1:0]              pos_q;
	logic [pdiq_pkg::PHASE_W-1:0]  phase_q;
	logic [pdiq_pkg::GATHER_W-1:0] gather_q;
	logic [pdiq_pkg::SLIP_W-1:0]   slip_q;
	logic                          pending_q;
	logic                          wide_q;

	logic                         advance;
	logic [pdiq_pkg::CMP_W-1:0]   pos_ext;
	logic                         sync_hit;
	logic                         in_payload;
	logic                         pair_done;
	logic                         block_end;

	assign advance  = valid_s1 && out_ready;
	assign in_ready = !valid_s1 || out_ready;

	// decode the current byte against position and mode
	always_comb begin
		pos_ext    = pdiq_pkg::CMP_W'(pos_q);
		sync_hit   = !in_block_q && (byte_s1 == pdiq_pkg::SYNC_LAST) && (window_q == SYNC_WIN);
		in_payload = in_block_q && (pos_ext >= HDR_C) &&
			(pos_ext < (wide_q ? END_WIDE_C : END_NARROW_C));
		pair_done  = in_payload && (phase_q == (wide_q ? PH_LAST_WIDE : PH_LAST_NARROW));
		block_end  = in_block_q && (pos_ext == BLK_LAST_C);
	end

	// form the sample pair from the gathered bytes and the closing byte
	always_comb begin
		if (wide_q) begin
			res.re_sample = gather_q[39:16];
			res.im_sample = {gather_q[15:0], byte_s1};
		end else begin
			res.re_sample = {gather_q[23:8], 8'h00};
			res.im_sample = {gather_q[7:0], byte_s1, 8'h00};
		end
		res.block_last = (pos_ext == ((wide_q ? END_WIDE_C : END_NARROW_C) - 10'd1));
		res.slip_bytes = pending_q ? slip_q : '0;
		res_valid      = advance && pair_done;
	end

	// hold the rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (cfg_wr_en) begin
			rate_q <= cfg_wr_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register data
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	// advance hunt and block state by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			fill_q     <= '0;
			in_block_q <= 1'b0;
			pos_q      <= '0;
			phase_q    <= '0;
			gather_q   <= '0;
			slip_q     <= '0;
			pending_q  <= 1'b0;
			wide_q     <= 1'b1;
		end else if (advance) begin
			if (!in_block_q) begin
				if (sync_hit) begin
					in_block_q <= 1'b1;
					pos_q      <= POS_START;
					phase_q    <= '0;
					gather_q   <= '0;
					wide_q     <= (rate_q < pdiq_pkg::WIDE_LIMIT);
					pending_q  <= 1'b1;
				end else begin
					if (fill_q == FILL_FULL) begin
						if (slip_q != pdiq_pkg::SLIP_MAX) begin
							slip_q <= slip_q + 16'd1;
						end
					end else begin
						fill_q <= fill_q + 3'd1;
					end
					window_q <= {window_q[pdiq_pkg::WIN_W-pdiq_pkg::BYTE_W-1:0], byte_s1};
				end
			end else begin
				// gather payload bytes, close a pair on its last byte
				if (in_payload) begin
					if (pair_done) begin
						gather_q <= '0;
						phase_q  <= '0;
						if (pending_q) begin
							pending_q <= 1'b0;
							slip_q    <= '0;
						end
					end else begin
						gather_q <= {gather_q[pdiq_pkg::GATHER_W-pdiq_pkg::BYTE_W-1:0], byte_s1};
						phase_q  <= phase_q + 3'd1;
					end
				end
				// drop back to hunting after the block's last byte
				if (block_end) begin
					in_block_q <= 1'b0;
					pos_q      <= '0;
					phase_q    <= '0;
					gather_q   <= '0;
					window_q   <= '0;
					fill_q     <= '0;
					if (pending_q) begin
						pending_q <= 1'b0;
						slip_q    <= '0;
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	`PDIQ_ASSERT_NOW(a_pos_in_block, clk, arst_n, in_block_q, pos_q >= POS_START)
	`PDIQ_ASSERT_NOW(a_hunt_clean, clk, arst_n, !in_block_q, (pos_q == '0) && (phase_q == '0))
	`PDIQ_ASSERT_NOW(a_pending_block, clk, arst_n, pending_q, in_block_q)
	`PDIQ_ASSERT_NOW(a_slip_first, clk, arst_n, res_valid && (res.slip_bytes != '0), pending_q)

endmodule

// ===== rtl/pdiq_out_reg.sv =====
// ----------------------------------------------------------------------------
// pdiq_out_reg
// Result register on the master side; takes a new pair while the current
// one is being taken.
// ----------------------------------------------------------------------------
`include "preamble_deframer_iq_unpacker_core_assert.svh"

module pdiq_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  pdiq_pkg::pair_t in_pair,
	output logic            ready,
	output logic            valid_q,
	output pdiq_pkg::pair_t pair_q,
	input  logic            m_tready
);

	assign ready = !valid_q || m_tready;

	// hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			pair_q <= in_pair;
		end
	end

	`PDIQ_ASSERT_NOW(a_no_overwrite, clk, arst_n, in_valid, ready)
	`PDIQ_ASSERT_NEXT(a_load_shows, clk, arst_n, in_valid, valid_q)

endmodule

// ===== rtl/preamble_deframer_iq_unpacker_core.sv =====
// Preamble deframer and IQ unpacker.
// Slave side takes one received byte per beat (s_tdata). The block hunts for
// seven 0x55 bytes and a 0xD5 that open a block of BLOCK_BYTES bytes, skips
// its HEADER_BYTES header (sync included) and unpacks the payload MSB first into
// signed 24-bit IQ pairs (rate index below 8) or 16-bit pairs shifted left by 8.
// Master side gives one pair per beat: real, imaginary and the slip count in
// m_tdata, tlast on the block's last pair. The slip count (bytes dropped
// before the preamble, saturating) is nonzero only on a block's first pair.
// cfg_wr_en/cfg_wr_data write the rate index; it is sampled at block start.
// A pair's last byte passes the input register, then the result register,
// before m_tvalid rises; a stall on the master side can hold it in between.
// Throughput is one byte per cycle while the result register can accept,
// as the state is updated from the input register for each byte.
// Reset clears the hunt state, slip count and both registers' valid bits; the
// rate index resets to 0. When the receiver stalls, the result register holds
// its beat, the input register fills and s_tready drops until the result is taken.

// ----------------------------------------------------------------------------
// preamble_deframer_iq_unpacker_core
// Top level: deframer with input register and result register.
// ----------------------------------------------------------------------------
module preamble_deframer_iq_unpacker_core #(
	parameter int BLOCK_BYTES  = 508,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,      // [23:0] re_sample, [47:24] im_sample, [63:48] slip_bytes
	output logic        m_tlast,      // block_last
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data   // rate_index
);

	logic            out_ready;
	logic            res_valid;
	pdiq_pkg::pair_t res;
	pdiq_pkg::pair_t pair_q;

	pdiq_deframer #(
		.BLOCK_BYTES  (BLOCK_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (out_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	pdiq_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_pair  (res),
		.ready    (out_ready),
		.valid_q  (m_tvalid),
		.pair_q   (pair_q),
		.m_tready (m_tready)
	);

	// pack the result beat
	assign m_tdata = {pair_q.slip_bytes, pair_q.im_sample, pair_q.re_sample};
	assign m_tlast = pair_q.block_last;

endmodule
